// ===== design/mlp_pkg.sv =====
package mlp_pkg;

    // Request opcodes
    localparam logic [1:0] OP_INFER = 2'd0;
    localparam logic [1:0] OP_TRAIN = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LR  = 1'b0;
    localparam logic CFG_ACT = 1'b1;

    localparam logic [15:0] LR_RESET = 16'd655;
    localparam int          NUM_W    = 9;
    localparam logic [3:0]  W_LAST   = 4'(NUM_W - 1);

    // Sigmoid table geometry: index taken from |net| below 8.0 in Q16
    localparam int SIG_N     = 256;
    localparam int SIG_IDX_W = $clog2(SIG_N);
    localparam int SIG_MAG_W = 19;

    typedef logic [16:0] t_sig_tab [SIG_N];

    localparam longint unsigned EXP_NEG_INT [8] = '{
        64'd2147483648, 64'd790015084, 64'd290630299, 64'd106916919,
        64'd39332535, 64'd14469631, 64'd5323080, 64'd1958252
    };

    // Unsigned floor quotient by shift and subtract, used at elaboration only
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned dvs);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= dvs) begin
                r    = r - dvs;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Build round(65536 * sigmoid(8*i/N)) with exp in Q31 at elaboration
    function automatic t_sig_tab build_sig_tab();
        t_sig_tab        tab;
        longint unsigned whole;
        longint unsigned rem;
        longint unsigned frac;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned ex;
        longint unsigned den;
        longint unsigned val;
        longint unsigned ii;
        for (int i = 0; i < SIG_N; i++) begin
            ii    = longint'(i);
            whole = (64'd8 * ii) / SIG_N;
            rem   = (64'd8 * ii) % SIG_N;
            frac  = (rem << 31) / SIG_N;
            sum   = 64'd1 << 31;
            term  = 64'd1 << 31;
            for (int k = 1; k <= 16; k++) begin
                term = div_u64((term * frac) >> 31, 64'(k));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            ex     = (sum * EXP_NEG_INT[whole[2:0]]) >> 31;
            den    = (64'd1 << 31) + ex;
            val    = div_u64((64'd1 << 47) + (den >> 1), den);
            tab[i] = val[16:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

    // Sequencer steps, in issue order
    typedef enum logic [5:0] {
        S_NONE, S_H1A, S_H1B, S_H2A, S_H2B, S_HACT, S_OA_LO, S_OA_HI,
        S_OB_LO, S_OB_HI, S_OSUM, S_OY,
        S_TG, S_TDO, S_TL1, S_TL2, S_TW6A, S_TW6B, S_TW7A, S_TW7B, S_TW8,
        S_TG1, S_TD1, S_TG2, S_TD2, S_TW0A, S_TW0B, S_TW1A, S_TW1B, S_TW2,
        S_TW3A, S_TW3B, S_TW4A, S_TW4B, S_TW5, S_TEND
    } t_step;

    typedef struct packed {
        logic  load;
        t_step step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic in_predict;
        logic train;
    } t_status;

endpackage

// ===== design/mlp_ctrl.sv =====
module mlp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall,
    input  mlp_pkg::t_status i_status,
    output mlp_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import mlp_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_state;

    t_state r_state;
    t_step  r_step;
    logic   r_valid;
    logic   load;
    logic   out_load;

    assign load     = (r_state == ST_IDLE) && i_valid;
    assign out_load = (r_state == ST_FIN) && (!r_valid || !i_stall);

    assign o_cmd   = '{load: load, step: r_step, out_load: out_load};
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    // Sequence the steps and hold the result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= S_NONE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (load) begin
                        if (i_status.in_predict) begin
                            r_state <= ST_RUN;
                            r_step  <= S_H1A;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_RUN: begin
                    if ((r_step == S_OY && !i_status.train) || r_step == S_TEND) begin
                        r_state <= ST_FIN;
                        r_step  <= S_NONE;
                    end else begin
                        r_step <= t_step'(r_step + 6'd1);
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_step  <= S_NONE;
                end
            endcase
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/mlp_dp.sv =====
module mlp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlp_pkg::t_cmd       i_cmd,
    output mlp_pkg::t_status    o_status,
    input  logic [15:0]         i_lr,
    input  logic                i_relu,
    input  logic [1:0]          i_op,
    input  logic signed [15:0]  i_x0,
    input  logic signed [15:0]  i_x1,
    input  logic                i_label,
    input  logic [3:0]          i_weight_index,
    input  logic signed [31:0]  i_weight_value,
    output logic [15:0]         o_prediction,
    output logic                o_predicted_class,
    output logic signed [31:0]  o_weight_out
);
    import mlp_pkg::*;

    logic signed [31:0] r_w [NUM_W];
    logic [1:0]         r_op;
    logic signed [15:0] r_x0;
    logic signed [15:0] r_x1;
    logic               r_label;
    logic [3:0]         r_idx;
    logic signed [70:0] r_prod;
    logic signed [71:0] r_acc;
    logic signed [37:0] r_n1;
    logic signed [37:0] r_n2;
    logic signed [49:0] r_onet;
    logic signed [31:0] r_h1;
    logic signed [31:0] r_h2;
    logic [15:0]        r_y;
    logic signed [18:0] r_do;
    logic signed [31:0] r_l1;
    logic signed [31:0] r_l2;
    logic signed [31:0] r_d1;
    logic signed [31:0] r_d2;
    logic [15:0]        r_pred;
    logic               r_cls;
    logic signed [31:0] r_wout;

    logic signed [50:0] a_op;
    logic signed [19:0] b_op;
    logic signed [17:0] link;
    logic signed [19:0] lr_op;
    logic signed [19:0] g_op;
    logic signed [71:0] hsum;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] q;
        if (v > 72'sd2147483647) begin
            q = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            q = 32'sh80000000;
        end else begin
            q = v[31:0];
        end
        return q;
    endfunction

    // Table sigmoid of a Q16 net, result clamped to 0..65535
    function automatic logic [15:0] sig_lookup(input logic signed [49:0] net);
        logic [49:0] mag;
        logic [16:0] s;
        mag = net[49] ? 50'(-net) : 50'(net);
        if (mag >= (50'd1 << SIG_MAG_W)) begin
            s = 17'h10000;
        end else begin
            s = SIG_TAB[mag[SIG_MAG_W-1 -: SIG_IDX_W]];
        end
        if (net[49]) begin
            s = 17'h10000 - s;
        end
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic signed [31:0] act(input logic signed [37:0] n,
                                               input logic relu);
        logic signed [31:0] h;
        if (relu) begin
            if (n <= 38'sd0) begin
                h = 32'sd0;
            end else if (n > 38'sd2147483647) begin
                h = 32'sh7FFFFFFF;
            end else begin
                h = n[31:0];
            end
        end else begin
            h = $signed({16'd0, sig_lookup(50'(n))});
        end
        return h;
    endfunction

    assign o_status.in_predict = !i_op[1];
    assign o_status.train      = (r_op == OP_TRAIN);

    assign link  = $signed({2'b00, r_y}) - (r_label ? 18'sd65536 : 18'sd0);
    assign lr_op = $signed({4'd0, i_lr});
    assign g_op  = $signed({3'd0, r_prod[32:16]});
    assign hsum  = r_acc + 72'(r_prod);

    // Pick multiplier operands for the current step
    always_comb begin
        a_op = '0;
        b_op = '0;
        case (i_cmd.step)
            S_H1A:   begin a_op = 51'(r_w[0]); b_op = 20'(r_x0); end
            S_H1B:   begin a_op = 51'(r_w[1]); b_op = 20'(r_x1); end
            S_H2A:   begin a_op = 51'(r_w[3]); b_op = 20'(r_x0); end
            S_H2B:   begin a_op = 51'(r_w[4]); b_op = 20'(r_x1); end
            S_OA_LO: begin a_op = 51'(r_w[6]); b_op = $signed({4'd0, r_h1[15:0]}); end
            S_OA_HI: begin a_op = 51'(r_w[6]); b_op = $signed({4'd0, r_h1[31:16]}); end
            S_OB_LO: begin a_op = 51'(r_w[7]); b_op = $signed({4'd0, r_h2[15:0]}); end
            S_OB_HI: begin a_op = 51'(r_w[7]); b_op = $signed({4'd0, r_h2[31:16]}); end
            S_TG: begin
                a_op = $signed({34'd0, 17'h10000 - {1'b0, r_y}});
                b_op = $signed({4'd0, r_y});
            end
            S_TDO:   begin a_op = 51'(link); b_op = g_op; end
            S_TL1:   begin a_op = 51'(r_w[6]); b_op = 20'($signed(r_prod[34:16])); end
            S_TL2:   begin a_op = 51'(r_w[7]); b_op = 20'(r_do); end
            S_TW6A:  begin a_op = 51'(r_h1); b_op = 20'(r_do); end
            S_TW7A:  begin a_op = 51'(r_h2); b_op = 20'(r_do); end
            S_TW6B, S_TW7B, S_TW0B, S_TW1B, S_TW3B, S_TW4B: begin
                a_op = r_prod[50:0];
                b_op = lr_op;
            end
            S_TW8:   begin a_op = 51'(r_do); b_op = lr_op; end
            S_TG1: begin
                a_op = $signed({34'd0, 17'h10000 - {1'b0, r_h1[15:0]}});
                b_op = $signed({4'd0, r_h1[15:0]});
            end
            S_TD1:   begin a_op = 51'(r_l1); b_op = g_op; end
            S_TG2: begin
                a_op = $signed({34'd0, 17'h10000 - {1'b0, r_h2[15:0]}});
                b_op = $signed({4'd0, r_h2[15:0]});
            end
            S_TD2:   begin a_op = 51'(r_l2); b_op = g_op; end
            S_TW0A:  begin a_op = 51'(r_d1); b_op = 20'(r_x0); end
            S_TW1A:  begin a_op = 51'(r_d1); b_op = 20'(r_x1); end
            S_TW2:   begin a_op = 51'(r_d1); b_op = lr_op; end
            S_TW3A:  begin a_op = 51'(r_d2); b_op = 20'(r_x0); end
            S_TW4A:  begin a_op = 51'(r_d2); b_op = 20'(r_x1); end
            S_TW5:   begin a_op = 51'(r_d2); b_op = lr_op; end
            default: begin a_op = '0; b_op = '0; end
        endcase
    end

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= a_op * b_op;
    end

    // Weight store: reset, host writes and gradient updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_W; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            if (i_cmd.load && i_op == OP_WRITE && i_weight_index <= W_LAST) begin
                r_w[i_weight_index] <= i_weight_value;
            end
            case (i_cmd.step)
                S_TW7A: r_w[6] <= sat32(72'(r_w[6]) - 72'(r_prod >>> 32));
                S_TW8:  r_w[7] <= sat32(72'(r_w[7]) - 72'(r_prod >>> 32));
                S_TG1:  r_w[8] <= sat32(72'(r_w[8]) - 72'(r_prod >>> 16));
                S_TW1A: r_w[0] <= sat32(72'(r_w[0]) - 72'(r_prod >>> 28));
                S_TW2:  r_w[1] <= sat32(72'(r_w[1]) - 72'(r_prod >>> 28));
                S_TW3A: r_w[2] <= sat32(72'(r_w[2]) - 72'(r_prod >>> 16));
                S_TW4A: r_w[3] <= sat32(72'(r_w[3]) - 72'(r_prod >>> 28));
                S_TW5:  r_w[4] <= sat32(72'(r_w[4]) - 72'(r_prod >>> 28));
                S_TEND: r_w[5] <= sat32(72'(r_w[5]) - 72'(r_prod >>> 16));
                default: ;
            endcase
        end
    end

    // Capture the request and fold the previous product into the working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_x0    <= i_x0;
            r_x1    <= i_x1;
            r_label <= i_label;
            r_idx   <= i_weight_index;
        end
        case (i_cmd.step)
            S_H1B, S_H2B: r_acc <= 72'(r_prod);
            S_H2A:   r_n1 <= 38'((hsum >>> 12) + 72'(r_w[2]));
            S_HACT: begin
                r_n2 <= 38'((hsum >>> 12) + 72'(r_w[5]));
                r_h1 <= act(r_n1, i_relu);
            end
            S_OA_LO: r_h2 <= act(r_n2, i_relu);
            S_OA_HI: r_acc <= 72'(r_prod);
            S_OB_LO: r_acc <= r_acc + (72'(r_prod) <<< 16);
            S_OB_HI: r_acc <= hsum;
            S_OSUM:  r_onet <= 50'(((r_acc + (72'(r_prod) <<< 16)) >>> 16)
                                   + 72'(r_w[8]));
            S_OY:    r_y <= sig_lookup(r_onet);
            S_TL1:   r_do <= r_prod[34:16];
            S_TL2:   r_l1 <= sat32(72'(r_prod >>> 16));
            S_TW6A:  r_l2 <= sat32(72'(r_prod >>> 16));
            S_TG2: begin
                if (i_relu) begin
                    r_d1 <= r_n1[37] ? 32'sd0 : r_l1;
                end else begin
                    r_d1 <= sat32(72'(r_prod >>> 16));
                end
            end
            S_TW0A: begin
                if (i_relu) begin
                    r_d2 <= r_n2[37] ? 32'sd0 : r_l2;
                end else begin
                    r_d2 <= sat32(72'(r_prod >>> 16));
                end
            end
            default: ;
        endcase
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pred <= r_op[1] ? 16'd0 : r_y;
            r_cls  <= !r_op[1] && r_y[15];
            if (r_op == OP_READ && r_idx <= W_LAST) begin
                r_wout <= r_w[r_idx];
            end else begin
                r_wout <= '0;
            end
        end
    end

    assign o_prediction      = r_pred;
    assign o_predicted_class = r_cls;
    assign o_weight_out      = r_wout;

endmodule

// ===== design/mlp_2_2_1_online_sgd.sv =====
// 2-2-1 sigmoid network with online gradient training.
// Input channel: i_valid / o_stall carries one request (op, x0, x1, label,
// weight_index, weight_value). Output channel: o_valid / i_stall returns one
// result per request (prediction, predicted_class, weight_out).
// Ops: infer, train (forward pass then one gradient step), write a weight,
// read a weight. A request is taken only while no other is in flight; the
// whole pass runs over one shared 51x20 multiplier with a product register,
// one multiply per cycle, and that sequence sets the rate.
// Write and read requests skip the step sequence and go straight to the
// output register. The block returns to idle once a result is loaded into
// the output register, so a result still waiting for the receiver does not
// block the next request from starting.
// When the receiver stalls, the result register holds and the block waits
// with the next finished result until the register frees up.
// Configuration writes (learning rate, hidden activation) take effect at once
// and the user must make them only while the block is idle; the block does
// not enforce this. Reset (i_rst_n low, synchronous) clears all nine weights
// to zero, sets the learning rate to 655 and selects sigmoid hidden neurons.
module mlp_2_2_1_online_sgd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_x0,
    input  logic signed [15:0] i_x1,
    input  logic               i_label,
    input  logic [3:0]         i_weight_index,
    input  logic signed [31:0] i_weight_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_prediction,
    output logic               o_predicted_class,
    output logic signed [31:0] o_weight_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import mlp_pkg::*;

    logic [15:0] r_lr;
    logic        r_relu;
    t_cmd        cmd;
    t_status     status;
    logic        busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= LR_RESET;
            r_relu <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LR:  r_lr   <= i_cfg_data;
                CFG_ACT: r_relu <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mlp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    mlp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_lr              (r_lr),
        .i_relu            (r_relu),
        .i_op              (i_op),
        .i_x0              (i_x0),
        .i_x1              (i_x1),
        .i_label           (i_label),
        .i_weight_index    (i_weight_index),
        .i_weight_value    (i_weight_value),
        .o_prediction      (o_prediction),
        .o_predicted_class (o_predicted_class),
        .o_weight_out      (o_weight_out)
    );

    assign o_stall = busy;

    // An accepted request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    // The class bit agrees with the top bit of the prediction
    a_class_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_predicted_class == o_prediction[15]))
        else $error("predicted class disagrees with prediction");

    // A read result carries no prediction
    a_read_no_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_weight_out != 32'sd0) |-> (o_prediction == 16'd0))
        else $error("weight read result with nonzero prediction");

endmodule
